// ===== sv/qalu_pkg.sv =====
package qalu_pkg;

    localparam int DATA_W = 20;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_CONJ  = 3'd5,
        OP_ROT   = 3'd6
    } t_opcode;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] b_w;
        logic signed [DATA_W-1:0] scale;
    } t_qalu_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] r0;
        logic signed [DATA_W-1:0] r1;
        logic signed [DATA_W-1:0] r2;
        logic signed [DATA_W-1:0] r3;
        logic signed [DATA_W-1:0] r4;
        logic signed [DATA_W-1:0] r5;
        logic signed [DATA_W-1:0] r6;
        logic signed [DATA_W-1:0] r7;
        logic signed [DATA_W-1:0] r8;
        logic                     saturated;
    } t_qalu_out;

endpackage

// ===== sv/quaternion_alu.sv =====
// Quaternion ALU: add, subtract, Hamilton product, scale, dot, conjugate and
// rotation matrix on signed fixed point values (DATA_W bits, FRAC_BITS fraction).
// Input channel: i_valid / i_data / o_stall; a request is taken on a clock edge
// with i_valid high and o_stall low. Output channel: o_valid / o_data / i_stall.
// Every request gives exactly one result.
// Pipeline of four register stages: operand select, 16 parallel multipliers,
// sum of products per result lane, then rounding and saturation into the
// output register. o_valid is the valid bit of the output stage, and one
// request is accepted every cycle while o_stall is low and i_valid is high.
// When the receiver stalls, the output register holds and empty stages still
// fill; o_stall rises only once all four stages hold data. Nothing is dropped.
// Reset (synchronous, active low) clears all stage valid bits; data registers
// are not reset.
module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_qalu_in  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_qalu_out o_data
);

    localparam int DW = DATA_W;
    localparam int F  = FRAC_BITS;
    localparam int AW = ((2 * DW > 2 * F + 1) ? 2 * DW : 2 * F + 1) + 5;

    localparam logic signed [AW-1:0] ONE  = AW'(1) <<< (2 * F);
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] MAXV = (AW'(1) <<< (DW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);

    function automatic logic signed [AW-1:0] lin(input logic signed [DW+1:0] v);
        logic signed [AW-1:0] e;
        e = AW'(v);
        return e <<< F;
    endfunction

    // stage handshake, bubbles collapse
    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: operand select; lane order x, y, z, w
    t_opcode                r1_op;
    logic signed [DW-1:0]   r1_a [4];
    logic signed [DW-1:0]   r1_b [4];
    logic signed [DW-1:0]   n1_a [4];
    logic signed [DW-1:0]   n1_b [4];

    always_comb begin
        n1_a[0] = i_data.a_x;
        n1_a[1] = i_data.a_y;
        n1_a[2] = i_data.a_z;
        n1_a[3] = i_data.a_w;
        case (i_data.opcode)
            OP_ROT: begin
                for (int i = 0; i < 4; i++) n1_b[i] = n1_a[i];
            end
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) n1_b[i] = i_data.scale;
            end
            default: begin
                n1_b[0] = i_data.b_x;
                n1_b[1] = i_data.b_y;
                n1_b[2] = i_data.b_z;
                n1_b[3] = i_data.b_w;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_op <= i_data.opcode;
            r1_a  <= n1_a;
            r1_b  <= n1_b;
        end
    end

    // stage 2: all sixteen cross products a[i] * b[j]
    t_opcode                r2_op;
    logic signed [DW-1:0]   r2_a [4];
    logic signed [DW-1:0]   r2_b [4];
    logic signed [2*DW-1:0] r2_p [4][4];

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r2_op <= r1_op;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r2_p[i][j] <= (2*DW)'(r1_a[i]) * (2*DW)'(r1_b[j]);
                end
            end
        end
    end

    // stage 3: exact sums per lane, kept with 2F fraction bits
    logic signed [AW-1:0]   e [4][4];
    logic signed [DW+1:0]   s_add [4];
    logic signed [DW+1:0]   s_sub [4];
    logic signed [DW+1:0]   s_neg [4];
    logic signed [AW-1:0]   n3_acc [9];
    logic signed [AW-1:0]   r3_acc [9];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) e[i][j] = AW'(r2_p[i][j]);
            s_add[i] = (DW+2)'(r2_a[i]) + (DW+2)'(r2_b[i]);
            s_sub[i] = (DW+2)'(r2_a[i]) - (DW+2)'(r2_b[i]);
            s_neg[i] = -(DW+2)'(r2_a[i]);
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) n3_acc[k] = '0;
        case (r2_op)
            OP_ADD: begin
                for (int i = 0; i < 4; i++) n3_acc[i] = lin(s_add[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) n3_acc[i] = lin(s_sub[i]);
            end
            OP_CONJ: begin
                for (int i = 0; i < 3; i++) n3_acc[i] = lin(s_neg[i]);
                n3_acc[3] = lin((DW+2)'(r2_a[3]));
            end
            OP_MUL: begin
                n3_acc[0] = e[3][0] + e[0][3] + e[2][1] - e[1][2];
                n3_acc[1] = e[3][1] + e[1][3] + e[0][2] - e[2][0];
                n3_acc[2] = e[3][2] + e[2][3] + e[1][0] - e[0][1];
                n3_acc[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2];
            end
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) n3_acc[i] = e[i][0];
            end
            OP_DOT: begin
                n3_acc[0] = e[0][0] + e[1][1] + e[2][2] + e[3][3];
            end
            OP_ROT: begin
                // b operands carry A here, so e[i][j] = a[i] * a[j]
                n3_acc[0] = ONE - ((e[1][1] + e[2][2]) <<< 1);
                n3_acc[1] = (e[0][1] + e[3][2]) <<< 1;
                n3_acc[2] = (e[0][2] - e[3][1]) <<< 1;
                n3_acc[3] = (e[0][1] - e[3][2]) <<< 1;
                n3_acc[4] = ONE - ((e[0][0] + e[2][2]) <<< 1);
                n3_acc[5] = (e[1][2] + e[3][0]) <<< 1;
                n3_acc[6] = (e[0][2] + e[3][1]) <<< 1;
                n3_acc[7] = (e[1][2] - e[3][0]) <<< 1;
                n3_acc[8] = ONE - ((e[0][0] + e[1][1]) <<< 1);
            end
            default: begin
                for (int k = 0; k < 9; k++) n3_acc[k] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) r3_acc <= n3_acc;
    end

    // stage 4: round half up, saturate, output register
    logic signed [AW-1:0]   rnd [9];
    logic signed [AW-1:0]   q [9];
    logic signed [DW-1:0]   n4_r [9];
    logic [8:0]             n4_sat;
    t_qalu_out              n4_out;
    t_qalu_out              r4_out;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            rnd[k] = r3_acc[k] + HALF;
            q[k]   = rnd[k] >>> F;
            if (q[k] > MAXV) begin
                n4_r[k]   = MAXV[DW-1:0];
                n4_sat[k] = 1'b1;
            end else if (q[k] < MINV) begin
                n4_r[k]   = MINV[DW-1:0];
                n4_sat[k] = 1'b1;
            end else begin
                n4_r[k]   = q[k][DW-1:0];
                n4_sat[k] = 1'b0;
            end
        end
        n4_out.r0        = n4_r[0];
        n4_out.r1        = n4_r[1];
        n4_out.r2        = n4_r[2];
        n4_out.r3        = n4_r[3];
        n4_out.r4        = n4_r[4];
        n4_out.r5        = n4_r[5];
        n4_out.r6        = n4_r[6];
        n4_out.r7        = n4_r[7];
        n4_out.r8        = n4_r[8];
        n4_out.saturated = |n4_sat;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) r4_out <= n4_out;
    end

    assign o_data = r4_out;

    // back-pressure reaches the input only with every stage full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled while the pipeline has room");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted request not captured in stage 1");

    a_hold_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy4) |=> (r_v3 && $stable(r3_acc[0]) && $stable(r3_acc[8])))
        else $error("stage 3 changed while blocked");

endmodule

// ===== verif/tb.sv =====
module tb
    import qalu_pkg::*;
();

    localparam int FRAC = 16;
    localparam logic signed [DATA_W-1:0] MX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE = 1 << FRAC;
    localparam logic signed [DATA_W-1:0] HALF = 1 << (FRAC - 1);
    localparam t_opcode OP_RSVD = t_opcode'(3'd7);
    localparam longint MAX_L = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint MIN_L = -MAX_L - 1;
    localparam longint RND_L = longint'(1) <<< (FRAC - 1);
    localparam longint UNIT_L = longint'(1) <<< (2 * FRAC);
    localparam int N_DIR = 23;
    localparam int PER_PHASE = 290;
    localparam int TX_IDLE[5] = '{0, 82, 0, 30, 0};
    localparam int RX_IDLE[5] = '{0, 0, 82, 30, 0};

    typedef struct {
        t_qalu_in  req;
        logic      pinned;
        t_qalu_out res;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_qalu_in  i_data;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_qalu_out o_data;

    t_qalu_out pending_results[$];
    t_dir_row  dir_rows[N_DIR];
    logic      pin_en;
    t_qalu_out pin_res;
    int        mismatch_cnt = 0;
    int        tx_pct = 0;
    int        rx_pct = 0;
    logic      hold_en = 1'b0;
    logic      hold_seen = 1'b0;
    int        hold_left = 0;

    quaternion_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_qalu_in qin(input t_opcode op,
            input logic signed [DATA_W-1:0] ax, ay, az, aw, bx, by, bz, bw, sc);
        t_qalu_in r;
        r.opcode = op;
        r.a_x = ax; r.a_y = ay; r.a_z = az; r.a_w = aw;
        r.b_x = bx; r.b_y = by; r.b_z = bz; r.b_w = bw;
        r.scale = sc;
        return r;
    endfunction

    function automatic t_qalu_out qout(
            input logic signed [DATA_W-1:0] v0, v1, v2, v3, v4, v5, v6, v7, v8,
            input logic sat);
        t_qalu_out r;
        r.r0 = v0; r.r1 = v1; r.r2 = v2; r.r3 = v3; r.r4 = v4;
        r.r5 = v5; r.r6 = v6; r.r7 = v7; r.r8 = v8;
        r.saturated = sat;
        return r;
    endfunction

    function automatic longint clamp(input longint v, inout logic hit);
        if (v > MAX_L) begin
            hit = 1'b1;
            return MAX_L;
        end
        if (v < MIN_L) begin
            hit = 1'b1;
            return MIN_L;
        end
        return v;
    endfunction

    // exact sum of products, half LSB added, floor back to FRAC bits
    function automatic longint fix_round(input longint s, inout logic hit);
        return clamp((s + RND_L) >>> FRAC, hit);
    endfunction

    function automatic t_qalu_out quat_eval(input t_qalu_in req);
        longint ax, ay, az, aw, bx, by, bz, bw, sc;
        longint v[9];
        logic hit;
        t_qalu_out r;
        ax = longint'(req.a_x); ay = longint'(req.a_y);
        az = longint'(req.a_z); aw = longint'(req.a_w);
        bx = longint'(req.b_x); by = longint'(req.b_y);
        bz = longint'(req.b_z); bw = longint'(req.b_w);
        sc = longint'(req.scale);
        hit = 1'b0;
        foreach (v[i]) v[i] = 0;
        case (req.opcode)
            OP_ADD: begin
                v[0] = clamp(ax + bx, hit); v[1] = clamp(ay + by, hit);
                v[2] = clamp(az + bz, hit); v[3] = clamp(aw + bw, hit);
            end
            OP_SUB: begin
                v[0] = clamp(ax - bx, hit); v[1] = clamp(ay - by, hit);
                v[2] = clamp(az - bz, hit); v[3] = clamp(aw - bw, hit);
            end
            OP_MUL: begin
                v[0] = fix_round(aw*bx + ax*bw + az*by - ay*bz, hit);
                v[1] = fix_round(aw*by + ay*bw + ax*bz - az*bx, hit);
                v[2] = fix_round(aw*bz + az*bw + ay*bx - ax*by, hit);
                v[3] = fix_round(aw*bw - ax*bx - ay*by - az*bz, hit);
            end
            OP_SCALE: begin
                v[0] = fix_round(ax*sc, hit); v[1] = fix_round(ay*sc, hit);
                v[2] = fix_round(az*sc, hit); v[3] = fix_round(aw*sc, hit);
            end
            OP_DOT: v[0] = fix_round(aw*bw + ax*bx + ay*by + az*bz, hit);
            OP_CONJ: begin
                v[0] = clamp(-ax, hit); v[1] = clamp(-ay, hit);
                v[2] = clamp(-az, hit); v[3] = aw;
            end
            OP_ROT: begin
                v[0] = fix_round(UNIT_L - 2*(ay*ay + az*az), hit);
                v[1] = fix_round(2*(ax*ay + aw*az), hit);
                v[2] = fix_round(2*(ax*az - aw*ay), hit);
                v[3] = fix_round(2*(ax*ay - aw*az), hit);
                v[4] = fix_round(UNIT_L - 2*(ax*ax + az*az), hit);
                v[5] = fix_round(2*(ay*az + aw*ax), hit);
                v[6] = fix_round(2*(ax*az + aw*ay), hit);
                v[7] = fix_round(2*(ay*az - aw*ax), hit);
                v[8] = fix_round(UNIT_L - 2*(ax*ax + ay*ay), hit);
            end
            default: ;
        endcase
        r.r0 = v[0][DATA_W-1:0]; r.r1 = v[1][DATA_W-1:0]; r.r2 = v[2][DATA_W-1:0];
        r.r3 = v[3][DATA_W-1:0]; r.r4 = v[4][DATA_W-1:0]; r.r5 = v[5][DATA_W-1:0];
        r.r6 = v[6][DATA_W-1:0]; r.r7 = v[7][DATA_W-1:0]; r.r8 = v[8][DATA_W-1:0];
        r.saturated = hit;
        return r;
    endfunction

    // full range, unit-ish, extremes, tiny (rounding) and near-saturation values
    function automatic logic signed [DATA_W-1:0] rand_fix();
        int k;
        k = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'($urandom);
            4, 5, 6: return DATA_W'($urandom_range(0, 2 * ONE) - ONE);
            7: begin
                case ($urandom_range(0, 5))
                    0: return MX;
                    1: return MN;
                    2: return '0;
                    3: return ONE;
                    4: return -ONE;
                    default: return DATA_W'(-1);
                endcase
            end
            8: return DATA_W'($urandom_range(0, 8) - 4);
            default: return ($urandom_range(0, 1) == 1) ? DATA_W'(MX - k) : DATA_W'(MN + k);
        endcase
    endfunction

    task automatic cmp_field(input string name,
            input logic signed [DATA_W-1:0] want, input logic signed [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic offer(input t_qalu_in req);
        while ($urandom_range(1, 100) <= tx_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        // first long hold-off starts as soon as the pressure phase begins
        if (hold_en && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = 64;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            if (hold_en && $urandom_range(0, 149) == 0) hold_left = $urandom_range(40, 80);
            i_stall = ($urandom_range(1, 100) <= rx_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_qalu_out want;
        if (i_rst_n) begin
            // check the departing result before logging the arriving request
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("r0", want.r0, o_data.r0);
                    cmp_field("r1", want.r1, o_data.r1);
                    cmp_field("r2", want.r2, o_data.r2);
                    cmp_field("r3", want.r3, o_data.r3);
                    cmp_field("r4", want.r4, o_data.r4);
                    cmp_field("r5", want.r5, o_data.r5);
                    cmp_field("r6", want.r6, o_data.r6);
                    cmp_field("r7", want.r7, o_data.r7);
                    cmp_field("r8", want.r8, o_data.r8);
                    cmp_field("saturated", DATA_W'(want.saturated),
                              DATA_W'(o_data.saturated));
                end
            end
            if (i_valid && !o_stall)
                pending_results.push_back(pin_en ? pin_res : quat_eval(i_data));
        end
    end

    initial begin
        int ph;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        pin_en  = 1'b0;
        pin_res = '0;

        dir_rows[0]  = '{qin(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         qout(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0)};
        dir_rows[1]  = '{qin(OP_ADD, MX, MX, MX, MX, MX, MX, MX, MX, MX), 1'b1,
                         qout(MX, MX, MX, MX, 0, 0, 0, 0, 0, 1'b1)};
        dir_rows[2]  = '{qin(OP_ADD, MN, MN, MN, MN, MN, MN, MN, MN, MN), 1'b1,
                         qout(MN, MN, MN, MN, 0, 0, 0, 0, 0, 1'b1)};
        dir_rows[3]  = '{qin(OP_ADD, MX, MX, MX, MX, MN, MN, MN, MN, 0), 1'b1,
                         qout(-1, -1, -1, -1, 0, 0, 0, 0, 0, 1'b0)};
        dir_rows[4]  = '{qin(OP_SUB, MN, MN, MN, MN, MX, MX, MX, MX, 0), 1'b1,
                         qout(MN, MN, MN, MN, 0, 0, 0, 0, 0, 1'b1)};
        dir_rows[5]  = '{qin(OP_SUB, MX, MX, MX, MX, MN, MN, MN, MN, 0), 1'b1,
                         qout(MX, MX, MX, MX, 0, 0, 0, 0, 0, 1'b1)};
        dir_rows[6]  = '{qin(OP_SUB, ONE, -ONE, 3, -7, -ONE, ONE, 9, 11, 5), 1'b0, '0};
        dir_rows[7]  = '{qin(OP_MUL, 0, 0, 0, ONE, ONE, -ONE, 12345, -54321, 0), 1'b0, '0};
        dir_rows[8]  = '{qin(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0), 1'b0, '0};
        dir_rows[9]  = '{qin(OP_MUL, MX, MX, MX, MX, MX, MX, MX, MX, 0), 1'b0, '0};
        dir_rows[10] = '{qin(OP_MUL, MN, MN, MN, MN, MN, MN, MN, MN, 0), 1'b0, '0};
        // exact halves: +0.5 LSB rounds up, -0.5 LSB rounds to zero
        dir_rows[11] = '{qin(OP_SCALE, 1, -1, MX, MN, 0, 0, 0, 0, HALF), 1'b0, '0};
        dir_rows[12] = '{qin(OP_SCALE, MN, MN, MN, MN, 0, 0, 0, 0, -ONE), 1'b0, '0};
        dir_rows[13] = '{qin(OP_SCALE, MX, MX, MN, MN, 0, 0, 0, 0, MX), 1'b0, '0};
        dir_rows[14] = '{qin(OP_DOT, MX, MX, MX, MX, MX, MX, MX, MX, MX), 1'b0, '0};
        dir_rows[15] = '{qin(OP_DOT, HALF, -HALF, ONE, 3, ONE, HALF, -1, HALF, 0), 1'b0, '0};
        // negating the most negative value clamps; w passes through
        dir_rows[16] = '{qin(OP_CONJ, MN, MN, MN, MN, MX, MX, MX, MX, MX), 1'b1,
                         qout(MX, MX, MX, MN, 0, 0, 0, 0, 0, 1'b1)};
        dir_rows[17] = '{qin(OP_CONJ, MX, -1, 0, 5, 1, 2, 3, 4, 7), 1'b1,
                         qout(MN + 1, 1, 0, 5, 0, 0, 0, 0, 0, 1'b0)};
        dir_rows[18] = '{qin(OP_ROT, 0, 0, 0, ONE, MX, MN, MX, MN, MX), 1'b1,
                         qout(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0)};
        dir_rows[19] = '{qin(OP_ROT, 0, 0, 46341, 46341, 0, 0, 0, 0, 0), 1'b0, '0};
        dir_rows[20] = '{qin(OP_ROT, MX, MX, MX, MX, 0, 0, 0, 0, 0), 1'b0, '0};
        dir_rows[21] = '{qin(OP_ROT, MN, MN, MN, MN, 0, 0, 0, 0, 0), 1'b0, '0};
        dir_rows[22] = '{qin(OP_RSVD, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1,
                         qout(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0)};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            pin_en = dir_rows[i].pinned;
            pin_res = dir_rows[i].res;
            offer(dir_rows[i].req);
        end
        pin_en = 1'b0;

        for (ph = 0; ph < 5; ph++) begin
            i_valid = 1'b0;
            @(posedge i_clk);
            tx_pct = TX_IDLE[ph];
            rx_pct = RX_IDLE[ph];
            // last phase: long receiver hold-offs against a full-rate sender
            hold_en = (ph == 4);
            @(negedge i_clk);
            repeat (PER_PHASE)
                offer(qin(t_opcode'(3'($urandom_range(0, 7))), rand_fix(), rand_fix(),
                          rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                          rand_fix(), rand_fix()));
        end

        i_valid = 1'b0;
        @(posedge i_clk);
        hold_en = 1'b0;
        rx_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule
